[rtl/scc_pkg.sv]
// Package for the sensor conditioning channel: widths, constants, register
// indexes and the structs passed between the channel, its CSR block and divider.
// No dependencies.
package scc_pkg;

   localparam int DATA_W     = 32;
   localparam int SCALE_W    = 16;
   localparam int ALPHA_W    = 17;
   localparam int PERIOD_W   = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int MUL_A_W    = 33;
   localparam int MUL_B_W    = 18;
   localparam int PROD_W     = MUL_A_W + MUL_B_W;
   localparam int DIVIDEND_W = 42;

   localparam logic [ALPHA_W-1:0]        ALPHA_ONE     = 17'd65536;
   localparam logic signed [MUL_B_W-1:0] RATE_MS_PER_S = 18'sd1000;
   localparam logic signed [DATA_W-1:0]  DATA_MAX      = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0]  DATA_MIN      = 32'sh8000_0000;

   localparam logic signed [SCALE_W-1:0] SCALE_RESET  = 16'sd256;
   localparam logic [PERIOD_W-1:0]       PERIOD_RESET = 16'd100;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SCALE  = 2'd0,
      CSR_OFFSET = 2'd1,
      CSR_ALPHA  = 2'd2,
      CSR_PERIOD = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic signed [SCALE_W-1:0] scale;
      logic signed [DATA_W-1:0]  offset;
      logic [ALPHA_W-1:0]        alpha;
      logic [PERIOD_W-1:0]       period_ms;
   } scc_cfg_type;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DATA_W-1:0]     divisor;
   } scc_div_req_type;

   typedef struct packed {
      logic                  done;
      logic [DIVIDEND_W-1:0] quotient;
   } scc_div_rsp_type;

endpackage

[rtl/scc_csr.sv]
// Configuration registers of the sensor conditioning channel.
// Depends on scc_pkg for the register indexes and the configuration struct.
module scc_csr import scc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_wr_data,
   output scc_cfg_type          cfg
);

   scc_cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_SCALE:  cfg_in.scale = signed'(csr_wr_data[SCALE_W-1:0]);
            CSR_OFFSET: cfg_in.offset = signed'(csr_wr_data);
            CSR_ALPHA: begin
               // An alpha above one is rejected and the old weight stays.
               if (csr_wr_data[ALPHA_W-1:0] <= ALPHA_ONE) begin
                  cfg_in.alpha = csr_wr_data[ALPHA_W-1:0];
               end
            end
            CSR_PERIOD: cfg_in.period_ms = csr_wr_data[PERIOD_W-1:0];
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.scale     <= SCALE_RESET;
         cfg_ff.offset    <= '0;
         cfg_ff.alpha     <= '0;
         cfg_ff.period_ms <= PERIOD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/scc_div.sv]
// Restoring divider for the rate estimate: one quotient bit per cycle.
// Depends on scc_pkg for widths and the request and response structs.
module scc_div import scc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  scc_div_req_type div_req,
   output scc_div_rsp_type div_rsp
);

   localparam int CNT_W = $clog2(DIVIDEND_W);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIVIDEND_W - 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DATA_W:0]       rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DATA_W-1:0]     dsr_ff, dsr_in;
   logic [DATA_W:0]       shifted;
   logic [DATA_W+1:0]     trial;

   assign shifted = {rem_ff[DATA_W-1:0], quo_ff[DIVIDEND_W-1]};
   assign trial   = {1'b0, shifted} - {2'b00, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dsr_in  = div_req.divisor;
      end else if (busy_ff) begin
         if (trial[DATA_W+1]) begin
            rem_in = shifted;
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b0};
         end else begin
            rem_in = trial[DATA_W:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b1};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

[rtl/sensor_conditioning_channel.sv]
// Sensor conditioning channel: scaling, moving average, min/max and rate estimate.
// Depends on scc_pkg, scc_csr and scc_div.
//
// One timer tick is one request transfer. A tick that does not fall due for a
// rate update passes the scale, offset, filter multiply, filter add and track
// states before its response is loaded, and the next request can be taken in
// the cycle after the load. A tick that updates the rate also passes the rate
// multiply and the 42-step bit-serial divider, which sets most of its time.
// An update with no elapsed time skips the divider. All multiplies go
// through one 33x18 signed multiplier whose product is registered, stepped by
// the sequencer below. req_stall is high while a tick is in work. A finished
// response sits in its own output register, so the next tick is taken while
// the response waits. A second finished tick then holds in the done state with
// req_stall high. Configuration writes belong to idle periods only; an alpha
// above one (65536) is ignored on write.
module sensor_conditioning_channel import scc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [SCALE_W-1:0] req_raw_sample,
   input  logic                     req_sample_present,
   input  logic [DATA_W-1:0]        req_time_ms,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [DATA_W-1:0] rsp_scaled_value,
   output logic signed [DATA_W-1:0] rsp_filtered_value,
   output logic signed [DATA_W-1:0] rsp_filtered_max,
   output logic signed [DATA_W-1:0] rsp_filtered_min,
   output logic signed [DATA_W-1:0] rsp_rate_per_second,
   output logic                     rsp_rate_updated,
   input  logic                     csr_wr_en,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [DATA_W-1:0]        csr_wr_data
);

   typedef enum logic [9:0] {
      ST_IDLE  = 10'b00_0000_0001,
      ST_SCALE = 10'b00_0000_0010,
      ST_OFFS  = 10'b00_0000_0100,
      ST_FMUL  = 10'b00_0000_1000,
      ST_FADD  = 10'b00_0001_0000,
      ST_TRACK = 10'b00_0010_0000,
      ST_RMUL  = 10'b00_0100_0000,
      ST_DIV   = 10'b00_1000_0000,
      ST_DIVW  = 10'b01_0000_0000,
      ST_DONE  = 10'b10_0000_0000
   } state_type;

   scc_cfg_type     cfg;
   scc_div_req_type div_req;
   scc_div_rsp_type div_rsp;

   scc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   scc_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   state_type state_ff, state_in;

   // Latched request.
   logic signed [SCALE_W-1:0] raw_ff, raw_in;
   logic                      present_ff, present_in;
   logic [DATA_W-1:0]         time_ff, time_in;

   // Channel state.
   logic signed [DATA_W-1:0] cur_ff, cur_in;
   logic signed [DATA_W-1:0] acc_ff, acc_in;
   logic signed [DATA_W-1:0] max_ff, max_in;
   logic signed [DATA_W-1:0] min_ff, min_in;
   logic signed [DATA_W-1:0] base_ff, base_in;
   logic [DATA_W-1:0]        base_time_ff, base_time_in;
   logic signed [DATA_W-1:0] rate_ff, rate_in;

   // Working registers.
   logic signed [PROD_W-1:0] prod_ff;
   logic [DATA_W-1:0]        elapsed_ff, elapsed_in;
   logic                     updated_ff, updated_in;
   logic                     neg_ff, neg_in;

   // Response register.
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] o_scaled_ff, o_filt_ff, o_max_ff, o_min_ff, o_rate_ff;
   logic                     o_upd_ff;
   logic                     load_rsp;

   // Shared multiplier.
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  prod_in;

   always_comb begin
      case (state_ff)
         ST_SCALE: begin
            mul_a = MUL_A_W'(raw_ff);
            mul_b = MUL_B_W'(cfg.scale);
         end
         ST_FMUL: begin
            mul_a = MUL_A_W'(acc_ff) - MUL_A_W'(cur_ff);
            mul_b = signed'({1'b0, cfg.alpha});
         end
         ST_RMUL: begin
            mul_a = MUL_A_W'(acc_ff) - MUL_A_W'(base_ff);
            mul_b = RATE_MS_PER_S;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);

   // Scaled value minus offset, saturated.
   logic signed [DATA_W+1:0] offs_diff;
   logic signed [DATA_W-1:0] offs_sat;
   assign offs_diff = (DATA_W+2)'(signed'(prod_ff[DATA_W-1:0])) - (DATA_W+2)'(cfg.offset);
   always_comb begin
      if (offs_diff[DATA_W+1:DATA_W-1] == 3'b000 || offs_diff[DATA_W+1:DATA_W-1] == 3'b111) begin
         offs_sat = offs_diff[DATA_W-1:0];
      end else if (offs_diff[DATA_W+1]) begin
         offs_sat = DATA_MIN;
      end else begin
         offs_sat = DATA_MAX;
      end
   end

   // The filter is value + alpha*(previous - value)/65536, rounded half up. The
   // result lies between previous and value, so it never leaves 32 bits.
   logic signed [PROD_W-1:0] rnd_sum;
   logic signed [PROD_W-1:0] rnd_shift;
   assign rnd_sum   = prod_ff + PROD_W'(32768);
   assign rnd_shift = rnd_sum >>> 16;

   // Saturated signed rate from the unsigned quotient magnitude.
   logic [DIVIDEND_W-1:0]    quo;
   logic signed [DATA_W-1:0] rate_sat;
   assign quo = div_rsp.quotient;
   always_comb begin
      if (neg_ff) begin
         if (quo[DIVIDEND_W-1:DATA_W] != '0 || (quo[DATA_W-1] && quo[DATA_W-2:0] != '0)) begin
            rate_sat = DATA_MIN;
         end else begin
            rate_sat = signed'(DATA_W'(0) - quo[DATA_W-1:0]);
         end
      end else begin
         if (quo[DIVIDEND_W-1:DATA_W-1] != '0) begin
            rate_sat = DATA_MAX;
         end else begin
            rate_sat = signed'(quo[DATA_W-1:0]);
         end
      end
   end

   logic [DIVIDEND_W-1:0] prod_mag;
   assign prod_mag = prod_ff[PROD_W-1] ? DIVIDEND_W'(-prod_ff) : DIVIDEND_W'(prod_ff);

   assign load_rsp = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in     = state_ff;
      raw_in       = raw_ff;
      present_in   = present_ff;
      time_in      = time_ff;
      cur_in       = cur_ff;
      acc_in       = acc_ff;
      max_in       = max_ff;
      min_in       = min_ff;
      base_in      = base_ff;
      base_time_in = base_time_ff;
      rate_in      = rate_ff;
      elapsed_in   = elapsed_ff;
      updated_in   = updated_ff;
      neg_in       = neg_ff;
      div_req      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               raw_in     = req_raw_sample;
               present_in = req_sample_present;
               time_in    = req_time_ms;
               state_in   = ST_SCALE;
            end
         end
         ST_SCALE: state_in = ST_OFFS;
         ST_OFFS: begin
            if (present_ff) begin
               cur_in = offs_sat;
            end
            state_in = ST_FMUL;
         end
         ST_FMUL: state_in = ST_FADD;
         ST_FADD: begin
            acc_in   = cur_ff + rnd_shift[DATA_W-1:0];
            state_in = ST_TRACK;
         end
         ST_TRACK: begin
            if (acc_ff > max_ff) begin
               max_in = acc_ff;
            end
            if (acc_ff < min_ff) begin
               min_in = acc_ff;
            end
            elapsed_in = time_ff - base_time_ff;
            updated_in = (elapsed_in >= DATA_W'(cfg.period_ms));
            state_in   = updated_in ? ST_RMUL : ST_DONE;
         end
         ST_RMUL: begin
            // The baseline moves even when no time passed; the rate then holds.
            base_in      = acc_ff;
            base_time_in = time_ff;
            state_in     = (elapsed_ff == '0) ? ST_DONE : ST_DIV;
         end
         ST_DIV: begin
            div_req.start    = 1'b1;
            div_req.dividend = prod_mag;
            div_req.divisor  = elapsed_ff;
            neg_in           = prod_ff[PROD_W-1];
            state_in         = ST_DIVW;
         end
         ST_DIVW: begin
            if (div_rsp.done) begin
               rate_in  = rate_sat;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cur_ff       <= '0;
         acc_ff       <= '0;
         max_ff       <= DATA_MIN;
         min_ff       <= DATA_MAX;
         base_ff      <= '0;
         base_time_ff <= '0;
         rate_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cur_ff       <= cur_in;
         acc_ff       <= acc_in;
         max_ff       <= max_in;
         min_ff       <= min_in;
         base_ff      <= base_in;
         base_time_ff <= base_time_in;
         rate_ff      <= rate_in;
      end
   end

   always_ff @(posedge clock) begin
      raw_ff     <= raw_in;
      present_ff <= present_in;
      time_ff    <= time_in;
      prod_ff    <= prod_in;
      elapsed_ff <= elapsed_in;
      updated_ff <= updated_in;
      neg_ff     <= neg_in;
      if (load_rsp) begin
         o_scaled_ff <= cur_ff;
         o_filt_ff   <= acc_ff;
         o_max_ff    <= max_ff;
         o_min_ff    <= min_ff;
         o_rate_ff   <= rate_ff;
         o_upd_ff    <= updated_ff;
      end
   end

   assign req_stall           = (state_ff != ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_scaled_value    = o_scaled_ff;
   assign rsp_filtered_value  = o_filt_ff;
   assign rsp_filtered_max    = o_max_ff;
   assign rsp_filtered_min    = o_min_ff;
   assign rsp_rate_per_second = o_rate_ff;
   assign rsp_rate_updated    = o_upd_ff;

`ifndef SYNTH
   a_extremes_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_filtered_max >= rsp_filtered_value)
                    && (rsp_filtered_min <= rsp_filtered_value))
      else $error("filtered value outside the tracked extremes");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_DIVW))
      else $error("divider finished outside the wait state");

   a_alpha_range: assert property (@(posedge clock) disable iff (reset)
      cfg.alpha <= ALPHA_ONE)
      else $error("alpha register above one");
`endif

endmodule

[tb/sv/scc_checker.sv]
// Checker for the sensor conditioning channel: tracks register writes, predicts
// each response from the accepted ticks and compares the response transfers.
// Depends on scc_pkg.
`timescale 1ns / 100ps
module scc_checker import scc_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  logic signed [SCALE_W-1:0] req_raw_sample,
   input  logic                      req_sample_present,
   input  logic [DATA_W-1:0]         req_time_ms,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  logic signed [DATA_W-1:0]  rsp_scaled_value,
   input  logic signed [DATA_W-1:0]  rsp_filtered_value,
   input  logic signed [DATA_W-1:0]  rsp_filtered_max,
   input  logic signed [DATA_W-1:0]  rsp_filtered_min,
   input  logic signed [DATA_W-1:0]  rsp_rate_per_second,
   input  logic                      rsp_rate_updated,
   input  logic                      csr_wr_en,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [DATA_W-1:0]         csr_wr_data,
   output int                        pending,
   output int                        failures
);

   typedef struct packed {
      logic signed [DATA_W-1:0] scaled;
      logic signed [DATA_W-1:0] filtered;
      logic signed [DATA_W-1:0] peak_high;
      logic signed [DATA_W-1:0] peak_low;
      logic signed [DATA_W-1:0] rate;
      logic                     updated;
   } tick_result_type;

   // Register copies.
   logic signed [SCALE_W-1:0]  scale_q;
   logic signed [DATA_W-1:0]   offset_q;
   logic [ALPHA_W-1:0]         alpha_q;
   logic [PERIOD_W-1:0]        period_q;

   // Channel state.
   logic signed [DATA_W-1:0]   value_q;
   logic signed [DATA_W-1:0]   average_q;
   logic signed [DATA_W-1:0]   peak_high_q;
   logic signed [DATA_W-1:0]   peak_low_q;
   logic signed [DATA_W-1:0]   base_filtered_q;
   logic [DATA_W-1:0]          base_time_q;
   logic signed [DATA_W-1:0]   rate_q;

   tick_result_type expected_ticks[$];
   int fail_count = 0;

   assign failures = fail_count;

   function automatic logic signed [DATA_W-1:0] clamp32(input longint v);
      if (v > longint'(DATA_MAX))
         return DATA_MAX;
      if (v < longint'(DATA_MIN))
         return DATA_MIN;
      return v[DATA_W-1:0];
   endfunction

   function automatic tick_result_type condition_tick(input logic signed [SCALE_W-1:0] raw,
                                                      input logic present,
                                                      input logic [DATA_W-1:0] now);
      longint weighted;
      longint diff;
      logic [DATA_W-1:0] elapsed;
      logic [ALPHA_W-1:0] fresh_weight;
      logic signed [DATA_W-1:0] smoothed;
      tick_result_type r;
      if (present)
         value_q = clamp32(longint'(raw) * longint'(scale_q) - longint'(offset_q));
      fresh_weight = ALPHA_ONE - alpha_q;
      weighted = longint'(alpha_q) * longint'(average_q)
               + longint'(fresh_weight) * longint'(value_q);
      // The arithmetic shift floors, so adding one half rounds up on ties.
      smoothed = clamp32((weighted + 64'sd32768) >>> 16);
      average_q = smoothed;
      if (smoothed > peak_high_q)
         peak_high_q = smoothed;
      if (smoothed < peak_low_q)
         peak_low_q = smoothed;
      elapsed = now - base_time_q;
      r.updated = 1'b0;
      if (elapsed >= {{(DATA_W-PERIOD_W){1'b0}}, period_q}) begin
         // With no time gone by the old estimate stays, but the baseline moves.
         if (elapsed != '0) begin
            diff = longint'(smoothed) - longint'(base_filtered_q);
            rate_q = clamp32((diff * 64'sd1000) / longint'(elapsed));
         end
         base_filtered_q = smoothed;
         base_time_q = now;
         r.updated = 1'b1;
      end
      r.scaled = value_q;
      r.filtered = smoothed;
      r.peak_high = peak_high_q;
      r.peak_low = peak_low_q;
      r.rate = rate_q;
      return r;
   endfunction

   task automatic check_field(input string field, input logic [DATA_W-1:0] want,
                              input logic [DATA_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d",
                  $time, field, $signed(want), $signed(got));
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      tick_result_type want;
      if (reset) begin
         scale_q = SCALE_RESET;
         offset_q = '0;
         alpha_q = '0;
         period_q = PERIOD_RESET;
         value_q = '0;
         average_q = '0;
         peak_high_q = DATA_MIN;
         peak_low_q = DATA_MAX;
         base_filtered_q = '0;
         base_time_q = '0;
         rate_q = '0;
         expected_ticks.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_SCALE:  scale_q = csr_wr_data[SCALE_W-1:0];
               CSR_OFFSET: offset_q = csr_wr_data;
               CSR_ALPHA: begin
                  // Weights above one are dropped and the old weight stays.
                  if (csr_wr_data[ALPHA_W-1:0] <= ALPHA_ONE)
                     alpha_q = csr_wr_data[ALPHA_W-1:0];
               end
               CSR_PERIOD: period_q = csr_wr_data[PERIOD_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_ticks.size() == 0) begin
               $display("%0t: response transfer with no tick outstanding", $time);
               fail_count++;
            end else begin
               want = expected_ticks.pop_front();
               check_field("scaled_value", want.scaled, rsp_scaled_value);
               check_field("filtered_value", want.filtered, rsp_filtered_value);
               check_field("filtered_max", want.peak_high, rsp_filtered_max);
               check_field("filtered_min", want.peak_low, rsp_filtered_min);
               check_field("rate_per_second", want.rate, rsp_rate_per_second);
               check_field("rate_updated", {31'b0, want.updated}, {31'b0, rsp_rate_updated});
            end
         end
         if (req_valid && !req_stall)
            expected_ticks.push_back(condition_tick(req_raw_sample, req_sample_present,
                                                    req_time_ms));
      end
      pending <= expected_ticks.size();
   end

endmodule

[tb/sv/testbench.sv]
// Top of the sensor conditioning channel testbench: clock, reset, tick stimulus,
// register settings and response stalls; the verdict comes from scc_checker.
// Depends on scc_pkg, scc_checker and the channel RTL.
`timescale 1ns / 100ps
module testbench;
   import scc_pkg::*;

   localparam int CYCLE_LIMIT  = 2_000_000;
   localparam int DRAIN_CYCLES = 80;
   localparam int RANDOM_TICKS = 1500;
   localparam int PHASES       = 8;
   localparam int HOLD_CYCLES  = 600;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic signed [SCALE_W-1:0] req_raw_sample = '0;
   logic                      req_sample_present = 1'b0;
   logic [DATA_W-1:0]         req_time_ms = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic signed [DATA_W-1:0]  rsp_scaled_value;
   logic signed [DATA_W-1:0]  rsp_filtered_value;
   logic signed [DATA_W-1:0]  rsp_filtered_max;
   logic signed [DATA_W-1:0]  rsp_filtered_min;
   logic signed [DATA_W-1:0]  rsp_rate_per_second;
   logic                      rsp_rate_updated;
   logic                      csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]      csr_index = '0;
   logic [DATA_W-1:0]         csr_wr_data = '0;

   int pending;
   int failures;

   int stall_pct = 0;
   int idle_pct = 0;
   logic hold_request = 1'b0;
   logic hold_taken = 1'b0;
   int hold_left = 0;
   int stall_left = 0;

   logic [DATA_W-1:0]   tick_ms = '0;
   logic [PERIOD_W-1:0] current_period = PERIOD_RESET;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   sensor_conditioning_channel u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_raw_sample      (req_raw_sample),
      .req_sample_present  (req_sample_present),
      .req_time_ms         (req_time_ms),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_scaled_value    (rsp_scaled_value),
      .rsp_filtered_value  (rsp_filtered_value),
      .rsp_filtered_max    (rsp_filtered_max),
      .rsp_filtered_min    (rsp_filtered_min),
      .rsp_rate_per_second (rsp_rate_per_second),
      .rsp_rate_updated    (rsp_rate_updated),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wr_data         (csr_wr_data)
   );

   scc_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_raw_sample      (req_raw_sample),
      .req_sample_present  (req_sample_present),
      .req_time_ms         (req_time_ms),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_scaled_value    (rsp_scaled_value),
      .rsp_filtered_value  (rsp_filtered_value),
      .rsp_filtered_max    (rsp_filtered_max),
      .rsp_filtered_min    (rsp_filtered_min),
      .rsp_rate_per_second (rsp_rate_per_second),
      .rsp_rate_updated    (rsp_rate_updated),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wr_data         (csr_wr_data),
      .pending             (pending),
      .failures            (failures)
   );

   // Response side: one long hold-off on request, otherwise random stall bursts.
   always @(posedge clock) begin
      if (hold_request && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
         stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80)
                                                     : $urandom_range(0, 3);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("timeout after %0d cycles", CYCLE_LIMIT);
      $display("testbench NOT OK");
      $finish;
   end

   // Offers one tick and returns at the edge of its transfer with valid still high.
   task automatic send_tick(input logic signed [SCALE_W-1:0] raw, input logic present,
                            input logic [DATA_W-1:0] now);
      int gap;
      gap = 0;
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
         gap = ($urandom_range(0, 14) == 0) ? $urandom_range(20, 100) : $urandom_range(1, 3);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_raw_sample <= raw;
      req_sample_present <= present;
      req_time_ms <= now;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= data;
      @(posedge clock);
   endtask

   // Upper bits beyond the scale and period widths are junk; an extra alpha write above
   // one must leave the weight unchanged.
   task automatic load_settings(input logic [SCALE_W-1:0] scale, input logic [DATA_W-1:0] offset,
                                input logic [ALPHA_W-1:0] alpha,
                                input logic [PERIOD_W-1:0] period);
      write_register(CSR_SCALE, {16'($urandom), scale});
      write_register(CSR_OFFSET, offset);
      write_register(CSR_ALPHA, {15'd0, alpha});
      write_register(CSR_ALPHA, $urandom_range(0, 1) ? 32'h0001_0001 : 32'h0001_FFFF);
      write_register(CSR_PERIOD, {16'($urandom), period});
      csr_wr_en <= 1'b0;
      current_period = period;
   endtask

   task automatic random_tick();
      logic [SCALE_W-1:0] raw;
      int pick;
      pick = $urandom_range(0, 9);
      case (pick)
         0: raw = 16'h7FFF;
         1: raw = 16'h8000;
         2, 3: raw = 16'(int'($urandom_range(0, 16)) - 8);
         default: raw = 16'($urandom);
      endcase
      pick = $urandom_range(0, 19);
      if (pick == 0)
         tick_ms = $urandom;
      else if (pick < 3)
         tick_ms = tick_ms + $urandom_range(0, 200000);
      else
         tick_ms = tick_ms + $urandom_range(0, current_period / 2 + 2);
      send_tick(raw, $urandom_range(0, 4) != 0, tick_ms);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: extremes of the sample, a held sample, timestamp wrap.
      send_tick(16'sd100, 1'b1, 32'd0);
      send_tick(16'sh7FFF, 1'b1, 32'd50);
      send_tick(16'sh8000, 1'b1, 32'd100);
      send_tick(16'sd5, 1'b0, 32'd150);
      send_tick(16'sd0, 1'b1, 32'hFFFF_FFFF);
      send_tick(16'sd1, 1'b1, 32'd30);
      send_tick(-16'sd1, 1'b1, 32'd99);

      // Positive saturation, zero period with no time gone by, rate saturation.
      wait_for_results();
      load_settings(16'h7FFF, 32'h8000_0000, 17'd0, 16'd0);
      send_tick(16'sh7FFF, 1'b1, 32'd5);
      send_tick(16'sh7FFF, 1'b1, 32'd5);
      send_tick(16'sh8000, 1'b1, 32'd6);
      send_tick(16'sd0, 1'b0, 32'd6);

      // Negative saturation with the filter frozen at a weight of one.
      wait_for_results();
      load_settings(16'h8000, 32'h7FFF_FFFF, ALPHA_ONE, 16'd1);
      send_tick(16'sh7FFF, 1'b1, 32'd10);
      send_tick(16'sh8000, 1'b1, 32'd11);
      send_tick(16'sd0, 1'b0, 32'd11);
      send_tick(16'sh8000, 1'b1, 32'd12);

      // Half weight: rounding of ties on both sides of zero.
      wait_for_results();
      load_settings(16'd256, 32'd0, 17'd32768, 16'd3);
      send_tick(-16'sd3, 1'b1, 32'd20);
      send_tick(16'sd3, 1'b1, 32'd21);
      send_tick(-16'sd1, 1'b1, 32'd22);
      send_tick(16'sd0, 1'b1, 32'd23);
      send_tick(16'sd1, 1'b1, 32'd24);
      send_tick(16'sh8000, 1'b1, 32'd25);
      send_tick(16'sh7FFF, 1'b1, 32'd26);
      tick_ms = 32'd26;

      for (int p = 0; p < PHASES; p++) begin
         wait_for_results();
         case (p)
            0: load_settings(16'd256, 32'd0, 17'd0, 16'd100);
            1: load_settings(16'h7FFF, 32'h8000_0000, ALPHA_ONE, 16'd0);
            2: load_settings(16'h8000, 32'h7FFF_FFFF, 17'd1, 16'hFFFF);
            3: load_settings(16'($urandom), $urandom, 17'd65535, 16'd1);
            default: load_settings(16'($urandom),
                                   $urandom_range(0, 1) ? $urandom
                                                        : 32'(int'($urandom_range(0, 4096)) - 2048),
                                   17'($urandom_range(0, 65536)),
                                   16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                                   : $urandom_range(0, 300)));
         endcase
         stall_pct <= (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 10 : 35);
         idle_pct <= (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 10 : 30);
         // The sender keeps offering ticks while responses are held off.
         if (p == 0)
            hold_request <= 1'b1;
         for (int n = 0; n < RANDOM_TICKS / PHASES; n++) begin
            if (p == 5 && n == 100)
               wait_for_results();
            random_tick();
         end
      end
      wait_for_results();

      if (failures == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule

[files.f]
rtl/scc_pkg.sv
rtl/scc_csr.sv
rtl/scc_div.sv
rtl/sensor_conditioning_channel.sv
tb/sv/scc_checker.sv
tb/sv/testbench.sv
